// ----- design/arft_pkg.sv -----
// Shared types and constants for the anchor range filter table.
// Used by arft_mac and anchor_range_filter_table; no dependencies.
`default_nettype none
package arft_pkg;

  localparam int ENTRIES = 8;
  localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int RW    = 16;
  localparam int LW    = 12;
  localparam int AW    = 9;
  localparam int ACC_W = 24;
  localparam int PRD_W = AW + RW;

  localparam logic [AW-1:0] ALPHA_ONE = 9'd256;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_OUTLIER   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd4;

  localparam logic [1:0] CFG_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [1:0] CFG_FLOOR = 2'd2;

  typedef struct packed {
    logic [2:0]           status;
    logic [RW-1:0]        range_now;
    logic [RW-1:0]        range_before;
    logic [RW-1:0]        range_oldest;
    logic signed [LW-1:0] level;
  } res_t;

  typedef struct packed {
    logic          clr;
    logic          en;
    logic [AW-1:0] a;
    logic [RW-1:0] b;
  } mac_req_t;

endpackage
`default_nettype wire

// ----- design/arft_mac.sv -----
// Shared multiply-accumulate unit for the exponential average.
// Depends on arft_pkg.
`default_nettype none
module arft_mac (
  input  wire logic                        clk_i,
  input  wire arft_pkg::mac_req_t          req_i,
  output logic [arft_pkg::ACC_W-1:0]       acc_o
);

  logic [arft_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [arft_pkg::PRD_W-1:0] prod;
  logic [arft_pkg::PRD_W-1:0] sum;

  always_comb begin
    prod  = arft_pkg::PRD_W'(req_i.a) * arft_pkg::PRD_W'(req_i.b);
    sum   = (req_i.clr ? '0 : arft_pkg::PRD_W'(acc_q)) + prod;
    acc_d = sum[arft_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ----- design/anchor_range_filter_table.sv -----
// Top level of the anchor range filter table: slot store, sequencer, output register.
// Depends on arft_pkg and arft_mac.
`default_nettype none
// One word in, one word out. An accepted word passes through S_SCAN, which walks every
// slot, and S_EVAL; an update whose previous range is below the floor then goes through
// S_WB, a smoothed update through S_MUL1, S_MUL2 and S_WB, and S_OUT moves the result
// to the result register, waiting while the output is stalled. The block is ready again
// once S_OUT is left, not before. The sequencer walks the slots one per cycle to find
// the address and the lowest free slot, and a smoothed update passes twice through the
// single 9x16 multiply-accumulate unit. The result register lets the next word in while
// a finished result waits. Configuration registers are written through cfg_we_i /
// cfg_index_i / cfg_wdata_i; index 3 is ignored.
module anchor_range_filter_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] anchor_addr_i,
  input  wire logic [15:0] range_mm_i,
  input  wire logic signed [11:0] signal_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      range_now_o,
  output logic [15:0]      range_before_o,
  output logic [15:0]      range_oldest_o,
  output logic signed [11:0] level_out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int IW = arft_pkg::IW;
  localparam int RW = arft_pkg::RW;
  localparam int LW = arft_pkg::LW;

  logic [2:0] state_q, state_d;

  logic [RW-1:0]             limit_q;
  logic [arft_pkg::AW-1:0]   alpha_q;
  logic [RW-1:0]             floor_q;

  logic [1:0]           op_q;
  logic [RW-1:0]        addr_q;
  logic [RW-1:0]        meas_q;
  logic signed [LW-1:0] lvl_q;

  logic [IW-1:0] cnt_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  logic          direct_q;

  logic [arft_pkg::ENTRIES-1:0] used_q;
  logic [RW-1:0]        slot_addr_q [arft_pkg::ENTRIES];
  logic [RW-1:0]        r0_q        [arft_pkg::ENTRIES];
  logic [RW-1:0]        r1_q        [arft_pkg::ENTRIES];
  logic [RW-1:0]        r2_q        [arft_pkg::ENTRIES];
  logic signed [LW-1:0] slvl_q      [arft_pkg::ENTRIES];

  arft_pkg::res_t res_q, res_d;
  arft_pkg::res_t out_q;
  logic           out_valid_q;

  arft_pkg::mac_req_t          mac_req;
  logic [arft_pkg::ACC_W-1:0]  acc;

  logic                    in_fire;
  logic                    scan_hit;
  logic                    scan_free;
  logic                    last;
  logic [RW-1:0]           prev;
  logic [RW-1:0]           diff;
  logic                    outlier;
  logic [arft_pkg::AW-1:0] alpha_sat;
  logic [RW-1:0]           next_rng;
  logic                    wr_add;
  logic                    wr_del;
  logic                    wr_upd;
  logic                    out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  assign scan_hit  = used_q[cnt_q] && (slot_addr_q[cnt_q] == addr_q) && (addr_q != '0);
  assign scan_free = ~used_q[cnt_q] & ~free_q;
  assign last      = (cnt_q == IW'(arft_pkg::ENTRIES - 1));

  assign prev      = r0_q[hit_idx_q];
  assign diff      = (prev > meas_q) ? (prev - meas_q) : (meas_q - prev);
  assign outlier   = (prev > floor_q) && (diff > limit_q);
  assign alpha_sat = (alpha_q > arft_pkg::ALPHA_ONE) ? arft_pkg::ALPHA_ONE : alpha_q;
  assign next_rng  = direct_q ? meas_q : acc[arft_pkg::ACC_W-1:8];

  always_comb begin
    mac_req.en  = (state_q == S_MUL1) || (state_q == S_MUL2);
    mac_req.clr = (state_q == S_MUL1);
    if (state_q == S_MUL1) begin
      mac_req.a = alpha_sat;
      mac_req.b = meas_q;
    end else begin
      mac_req.a = arft_pkg::ALPHA_ONE - alpha_sat;
      mac_req.b = prev;
    end
  end

  arft_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    wr_add  = 1'b0;
    wr_del  = 1'b0;
    wr_upd  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_d   = '0;
        state_d = S_OUT;
        if (op_q == arft_pkg::OP_ADD) begin
          if (addr_q == '0 || hit_q) begin
            res_d.status = arft_pkg::ST_BAD_ADDR;
          end else if (!free_q) begin
            res_d.status = arft_pkg::ST_FULL;
          end else begin
            res_d.status = arft_pkg::ST_OK;
            wr_add       = 1'b1;
          end
        end else if (!hit_q) begin
          res_d.status = arft_pkg::ST_NOT_FOUND;
        end else begin
          case (op_q)
            arft_pkg::OP_UPDATE: begin
              if (outlier) begin
                res_d.status       = arft_pkg::ST_OUTLIER;
                res_d.range_now    = prev;
                res_d.range_before = r1_q[hit_idx_q];
                res_d.range_oldest = r2_q[hit_idx_q];
                res_d.level        = slvl_q[hit_idx_q];
              end else if (prev < floor_q) begin
                state_d = S_WB;
              end else begin
                state_d = S_MUL1;
              end
            end
            arft_pkg::OP_DELETE: begin
              res_d.status = arft_pkg::ST_OK;
              wr_del       = 1'b1;
            end
            default: begin
              res_d.status       = arft_pkg::ST_OK;
              res_d.range_now    = prev;
              res_d.range_before = r1_q[hit_idx_q];
              res_d.range_oldest = r2_q[hit_idx_q];
              res_d.level        = slvl_q[hit_idx_q];
            end
          endcase
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_WB;
      S_WB: begin
        wr_upd             = 1'b1;
        res_d.status       = arft_pkg::ST_OK;
        res_d.range_now    = next_rng;
        res_d.range_before = prev;
        res_d.range_oldest = r1_q[hit_idx_q];
        res_d.level        = lvl_q;
        state_d            = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= 16'd1500;
      alpha_q     <= 9'd64;
      floor_q     <= 16'd10;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          arft_pkg::CFG_LIMIT: limit_q <= cfg_wdata_i;
          arft_pkg::CFG_ALPHA: alpha_q <= cfg_wdata_i[arft_pkg::AW-1:0];
          arft_pkg::CFG_FLOOR: floor_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (!last) begin
          cnt_q <= cnt_q + IW'(1);
        end
        if (scan_hit) begin
          hit_q <= 1'b1;
        end
        if (scan_free) begin
          free_q <= 1'b1;
        end
      end
      if (wr_add) begin
        used_q[free_idx_q] <= 1'b1;
      end
      if (wr_del) begin
        used_q[hit_idx_q] <= 1'b0;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_i;
      addr_q <= anchor_addr_i;
      meas_q <= range_mm_i;
      lvl_q  <= signal_level_i;
    end
    if (state_q == S_SCAN) begin
      if (scan_hit) begin
        hit_idx_q <= cnt_q;
      end
      if (scan_free) begin
        free_idx_q <= cnt_q;
      end
    end
    if (state_q == S_EVAL) begin
      direct_q <= (prev < floor_q);
    end
    res_q <= res_d;
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
    if (wr_add) begin
      slot_addr_q[free_idx_q] <= addr_q;
      r0_q[free_idx_q]        <= '0;
      r1_q[free_idx_q]        <= '0;
      r2_q[free_idx_q]        <= '0;
      slvl_q[free_idx_q]      <= '0;
    end
    if (wr_upd) begin
      r0_q[hit_idx_q]   <= next_rng;
      r1_q[hit_idx_q]   <= prev;
      r2_q[hit_idx_q]   <= r1_q[hit_idx_q];
      slvl_q[hit_idx_q] <= lvl_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign range_now_o    = out_q.range_now;
  assign range_before_o = out_q.range_before;
  assign range_oldest_o = out_q.range_oldest;
  assign level_out_o    = out_q.level;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a word while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= arft_pkg::ST_BAD_ADDR)
    else $error("status code out of range");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == arft_pkg::ST_NOT_FOUND || status_o == arft_pkg::ST_FULL ||
    status_o == arft_pkg::ST_BAD_ADDR) |-> range_now_o == '0 && level_out_o == '0)
    else $error("error result carries entry data");
`endif

endmodule
`default_nettype wire
